// ----- sv/master_gain_clip_peak_meter_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the master gain, clip and peak meter unit
// Immediate-implication and next-cycle checks on a synchronous reset domain.
// ----------------------------------------------------------------------------
`ifndef MASTER_GAIN_CLIP_PEAK_METER_UNIT_ASSERT_SVH
`define MASTER_GAIN_CLIP_PEAK_METER_UNIT_ASSERT_SVH

// check cons in the same cycle as ante
`define MGCP_CHECK(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// check cons in the cycle after ante
`define MGCP_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/mgcp_pkg.sv -----
// ----------------------------------------------------------------------------
// Master gain, clip and peak meter package
// Widths, request codes and payload types shared by the unit and its divider.
// ----------------------------------------------------------------------------
package mgcp_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int PEAK_W      = SAMPLE_BITS - 1;
   localparam int PROD_W      = SAMPLE_BITS + 8;
   localparam int RND_W       = SAMPLE_BITS + 1;
   localparam int DEN_W       = SAMPLE_BITS + 9;
   localparam int DIV_W       = SAMPLE_BITS + 17;
   localparam int GAIN_W      = 9;
   localparam int VOL_W       = 8;
   localparam int OVR_W       = 15;
   localparam int CNT_W       = 4;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_VOLUME = 2'd1;
   localparam logic [1:0] KIND_START  = 2'd2;
   localparam logic [1:0] KIND_END    = 2'd3;

   localparam logic [GAIN_W-1:0] GAIN_UNITY = 9'd256;
   localparam logic [OVR_W-1:0]  FULL_SCALE = 15'd32767;
   localparam logic [PROD_W-1:0] FULL_Q8    = PROD_W'(32767 * 256);
   localparam logic [DIV_W-1:0]  NUM_SCALE  = DIV_W'(2 * 32767 * 256);
   localparam logic [PEAK_W-1:0] PEAK_MAX   = {PEAK_W{1'b1}};
   localparam logic [CNT_W-1:0]  DIV_STEPS  = CNT_W'(GAIN_W);

   typedef struct packed {
      logic [1:0]                    kind;
      logic signed [SAMPLE_BITS-1:0] left_in;
      logic signed [SAMPLE_BITS-1:0] right_in;
      logic [VOL_W-1:0]              new_volume;
      logic                          meter_was_read;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
      logic [PEAK_W-1:0]             peak_left_out;
      logic [PEAK_W-1:0]             peak_right_out;
      logic [OVR_W-1:0]              overall_peak_out;
      logic                          clipped;
      logic [GAIN_W-1:0]             gain_now;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- sv/master_gain_clip_peak_meter_unit.sv -----
// ----------------------------------------------------------------------------
// Master gain, clip and peak meter unit
// Scales stereo pairs by a Q8 gain and tracks peaks; with decrease_on_clip set it clips and lowers the gain.
//
//   port group  direction  handshake            carries
//   req_        in         req_valid/req_stall  sample pair or block command
//   rsp_        out        rsp_valid/rsp_stall  samples, peaks, clip, gain
//   csr_        in         csr_write_en         decrease_on_clip
//
// A sample pair passes ST_MUL and ST_EVAL for each channel, then ST_OUT; a channel
// that clips with decrease_on_clip set also waits in ST_DIV (9-step divider).
// Volume and block requests go from ST_IDLE straight to ST_OUT. One request is in
// flight at a time; req_stall stays high until the response is taken. rsp_stall
// holds the response. Synchronous reset restores unity gain and resets the meter.
// ----------------------------------------------------------------------------
`include "master_gain_clip_peak_meter_unit_assert.svh"

module master_gain_clip_peak_meter_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mgcp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mgcp_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic              csr_write_data
);
   import mgcp_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_EVAL = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type               state_ff, state_in;
   req_type                 req_ff, req_in;
   logic                    chan_ff, chan_in;
   logic                    neg_ff, neg_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [GAIN_W-1:0]       gain_ff, gain_in;
   logic [PEAK_W-1:0]       peak_l_ff, peak_l_in;
   logic [PEAK_W-1:0]       peak_r_ff, peak_r_in;
   logic [OVR_W-1:0]        overall_ff, overall_in;
   logic                    clip_ff, clip_in;
   logic                    dec_ff;
   logic [SAMPLE_BITS-1:0]  lo_ff, lo_in;
   logic [SAMPLE_BITS-1:0]  ro_ff, ro_in;

   logic [SAMPLE_BITS-1:0]  sample_sel;
   logic [SAMPLE_BITS-1:0]  mag;
   logic [PROD_W-1:0]       mul_w;
   logic [PROD_W:0]         rnd_sum;
   logic [RND_W-1:0]        rnd;
   logic [PEAK_W-1:0]       pk;
   logic [PEAK_W-1:0]       cur_peak;
   logic                    over;
   logic [RND_W-1:0]        outmag;
   logic [RND_W-1:0]        negmag;
   logic [SAMPLE_BITS-1:0]  outval;
   logic [PEAK_W-1:0]       end_l, end_r;
   logic                    big_l, big_r;
   logic [OVR_W-1:0]        ovr_mid, ovr_end;

   logic                    div_start;
   logic [DIV_W-1:0]        div_num;
   logic [DEN_W-1:0]        div_den;
   div_stat_type            div_stat;
   logic [GAIN_W-1:0]       div_quot;

   logic                    req_take;
   logic                    end_out;
   logic                    end_ok;

   mgcp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat),
      .quot  (div_quot)
   );

   // channel datapath
   assign sample_sel = chan_ff ? req_ff.right_in : req_ff.left_in;
   assign mag        = sample_sel[SAMPLE_BITS-1] ? (~sample_sel + 1'b1) : sample_sel;
   assign mul_w      = PROD_W'(mag) * PROD_W'(gain_ff);
   assign rnd_sum    = {1'b0, prod_ff} + (PROD_W + 1)'(128);
   assign rnd        = rnd_sum[PROD_W:8];
   assign pk         = (rnd > RND_W'(PEAK_MAX)) ? PEAK_MAX : rnd[PEAK_W-1:0];
   assign cur_peak   = chan_ff ? peak_r_ff : peak_l_ff;
   assign over       = dec_ff && (prod_ff > FULL_Q8);
   assign outmag     = over ? RND_W'(FULL_SCALE) : rnd;
   assign negmag     = ~outmag + 1'b1;
   assign outval     = neg_ff ? negmag[SAMPLE_BITS-1:0] : outmag[SAMPLE_BITS-1:0];
   assign div_num    = DIV_W'(gain_ff) * NUM_SCALE + DIV_W'(prod_ff);
   assign div_den    = {prod_ff, 1'b0};

   // block end clamp
   assign big_l   = peak_l_ff > PEAK_W'(FULL_SCALE);
   assign big_r   = peak_r_ff > PEAK_W'(FULL_SCALE);
   assign end_l   = big_l ? PEAK_W'(FULL_SCALE) :
                    (peak_l_ff == '0) ? PEAK_W'(1) : peak_l_ff;
   assign end_r   = big_r ? PEAK_W'(FULL_SCALE) :
                    (peak_r_ff == '0) ? PEAK_W'(1) : peak_r_ff;
   assign ovr_mid = (end_l[OVR_W-1:0] > overall_ff) ? end_l[OVR_W-1:0] : overall_ff;
   assign ovr_end = (end_r[OVR_W-1:0] > ovr_mid) ? end_r[OVR_W-1:0] : ovr_mid;

   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      chan_in    = chan_ff;
      neg_in     = neg_ff;
      prod_in    = prod_ff;
      gain_in    = gain_ff;
      peak_l_in  = peak_l_ff;
      peak_r_in  = peak_r_ff;
      overall_in = overall_ff;
      clip_in    = clip_ff;
      lo_in      = lo_ff;
      ro_in      = ro_ff;
      div_start  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in  = req_data;
               chan_in = 1'b0;
               lo_in   = '0;
               ro_in   = '0;
               state_in = ST_OUT;
               case (req_data.kind)
                  KIND_SAMPLE: begin
                     state_in = ST_MUL;
                  end
                  KIND_VOLUME: begin
                     gain_in = GAIN_W'(req_data.new_volume);
                  end
                  KIND_START: begin
                     if (req_data.meter_was_read) begin
                        peak_l_in = peak_l_ff >> 1;
                        peak_r_in = peak_r_ff >> 1;
                     end
                  end
                  KIND_END: begin
                     peak_l_in  = end_l;
                     peak_r_in  = end_r;
                     clip_in    = clip_ff | big_l | big_r;
                     overall_in = ovr_end;
                  end
                  default: begin
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_MUL: begin
            prod_in  = mul_w;
            neg_in   = sample_sel[SAMPLE_BITS-1];
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (pk > cur_peak) begin
               if (chan_ff) begin
                  peak_r_in = pk;
               end else begin
                  peak_l_in = pk;
               end
            end
            if (chan_ff) begin
               ro_in = outval;
            end else begin
               lo_in = outval;
            end
            if (over) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else if (!chan_ff) begin
               chan_in  = 1'b1;
               state_in = ST_MUL;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               gain_in = div_quot;
               if (!chan_ff) begin
                  chan_in  = 1'b1;
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      chan_ff <= chan_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      lo_ff   <= lo_in;
      ro_ff   <= ro_in;
      if (reset) begin
         state_ff   <= ST_IDLE;
         gain_ff    <= GAIN_UNITY;
         peak_l_ff  <= PEAK_W'(1);
         peak_r_ff  <= PEAK_W'(1);
         overall_ff <= '0;
         clip_ff    <= 1'b0;
         dec_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         gain_ff    <= gain_in;
         peak_l_ff  <= peak_l_in;
         peak_r_ff  <= peak_r_in;
         overall_ff <= overall_in;
         clip_ff    <= clip_in;
         if (csr_write_en) begin
            dec_ff <= csr_write_data;
         end
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = state_ff == ST_OUT;

   assign rsp_data.left_out         = lo_ff;
   assign rsp_data.right_out        = ro_ff;
   assign rsp_data.peak_left_out    = peak_l_ff;
   assign rsp_data.peak_right_out   = peak_r_ff;
   assign rsp_data.overall_peak_out = overall_ff;
   assign rsp_data.clipped          = clip_ff;
   assign rsp_data.gain_now         = gain_ff;

   assign req_take = req_valid && !req_stall;
   assign end_out  = (state_ff == ST_OUT) && (req_ff.kind == KIND_END);
   assign end_ok   = (peak_l_ff != '0) && (peak_r_ff != '0) &&
                     (peak_l_ff <= PEAK_W'(FULL_SCALE)) && (peak_r_ff <= PEAK_W'(FULL_SCALE));

   `MGCP_CHECK(a_gain_range, clock, reset, 1'b1, gain_ff <= GAIN_UNITY, "gain above unity")
   `MGCP_CHECK(a_div_no_raise, clock, reset, div_stat.done, div_quot <= gain_ff, "clip raised gain")
   `MGCP_CHECK(a_div_in_div, clock, reset, div_stat.busy, state_ff == ST_DIV, "stray divide")
   `MGCP_CHECK_NEXT(a_busy_after_req, clock, reset, req_take, req_stall, "request not held busy")
   `MGCP_CHECK(a_end_clamp, clock, reset, end_out, end_ok, "block end peak out of range")

endmodule

// ----- sv/mgcp_div.sv -----
// ----------------------------------------------------------------------------
// Gain reduction divider
// Restoring divider, one quotient bit per cycle, for a quotient of GAIN_W bits.
// ----------------------------------------------------------------------------
module mgcp_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [mgcp_pkg::DIV_W-1:0]   num,
   input  logic [mgcp_pkg::DEN_W-1:0]   den,
   output mgcp_pkg::div_stat_type       stat,
   output logic [mgcp_pkg::GAIN_W-1:0]  quot
);
   import mgcp_pkg::*;

   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  dsh_ff, dsh_in;
   logic [GAIN_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              fits;

   assign fits = rem_ff >= dsh_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         dsh_in  = DIV_W'(den) << (GAIN_W - 1);
         q_in    = '0;
         cnt_in  = DIV_STEPS;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         q_in    = {q_ff[GAIN_W-2:0], fits};
         dsh_in  = dsh_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         busy_in = cnt_ff != CNT_W'(1);
         done_in = cnt_ff == CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = q_ff;

endmodule

// ----- verif/tb_master_gain_clip_peak_meter_unit.sv -----
// ----------------------------------------------------------------------------
// Testbench for the master gain, clip and peak meter unit
// Feeds directed and random requests (sample pairs, volume and block
// commands) with random request gaps and response stalls (none in the calm phase),
// and checks every response against an in-bench predictor of gain, clip and meter state.
// The clip-gain-reduction mode is switched between phases with the unit idle.
// ----------------------------------------------------------------------------
module tb_master_gain_clip_peak_meter_unit;
   import mgcp_pkg::*;

   logic    clock          = 1'b0;
   logic    reset          = 1'b1;
   logic    req_valid      = 1'b0;
   logic    req_stall;
   req_type req_data       = '0;
   logic    rsp_valid;
   logic    rsp_stall      = 1'b0;
   rsp_type rsp_data;
   logic    csr_write_en   = 1'b0;
   logic    csr_write_data = 1'b0;

   master_gain_clip_peak_meter_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // predictor state
   logic [GAIN_W-1:0] gain_q8     = GAIN_UNITY;
   logic [PEAK_W-1:0] peak_l      = PEAK_W'(1);
   logic [PEAK_W-1:0] peak_r      = PEAK_W'(1);
   logic [OVR_W-1:0]  overall_pk  = '0;
   logic              clip_seen   = 1'b0;
   logic              clip_cut_en = 1'b0;

   req_type req_backlog[$];
   rsp_type reports_due[$];
   bit      req_taken    = 1'b0;
   bit      steady       = 1'b0;
   int      faults       = 0;
   int      reports_seen = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [SAMPLE_BITS-1:0] scale_sample(
      input logic signed [SAMPLE_BITS-1:0] x,
      inout logic [PEAK_W-1:0]             peak);
      longint      sx;
      logic [63:0] mag;
      logic [63:0] prod;
      logic [63:0] rnd;
      logic [63:0] outmag;
      sx   = x;
      mag  = (sx < 0) ? -sx : sx;
      prod = mag * gain_q8;
      rnd  = (prod + 64'd128) >> 8;
      if (rnd > peak) begin
         peak = (rnd > PEAK_MAX) ? PEAK_MAX : PEAK_W'(rnd);
      end
      outmag = rnd;
      if (clip_cut_en && prod > FULL_Q8) begin
         gain_q8 = GAIN_W'((2 * 64'(gain_q8) * FULL_Q8 + prod) / (2 * prod));
         outmag  = FULL_SCALE;
      end
      return (sx < 0) ? SAMPLE_BITS'(-outmag) : SAMPLE_BITS'(outmag);
   endfunction

   function automatic void settle_peak(inout logic [PEAK_W-1:0] peak);
      if (peak > FULL_SCALE) begin
         clip_seen = 1'b1;
         peak      = PEAK_W'(FULL_SCALE);
      end else if (peak < 1) begin
         peak = PEAK_W'(1);
      end
   endfunction

   function automatic rsp_type predict_report(input req_type rq);
      rsp_type rs;
      rs = '0;
      case (rq.kind)
         KIND_SAMPLE: begin
            rs.left_out  = scale_sample(rq.left_in, peak_l);
            rs.right_out = scale_sample(rq.right_in, peak_r);
         end
         KIND_VOLUME: begin
            gain_q8 = GAIN_W'(rq.new_volume);
         end
         KIND_START: begin
            if (rq.meter_was_read) begin
               peak_l = peak_l >> 1;
               peak_r = peak_r >> 1;
            end
         end
         default: begin
            settle_peak(peak_l);
            settle_peak(peak_r);
            if (peak_l > overall_pk) overall_pk = OVR_W'(peak_l);
            if (peak_r > overall_pk) overall_pk = OVR_W'(peak_r);
         end
      endcase
      rs.peak_left_out    = peak_l;
      rs.peak_right_out   = peak_r;
      rs.overall_peak_out = overall_pk;
      rs.clipped          = clip_seen;
      rs.gain_now         = gain_q8;
      return rs;
   endfunction

   function automatic req_type make_req(input logic [1:0] kind, input int lv, input int rv,
                                        input int vol, input bit rd);
      req_type rq;
      rq.kind           = kind;
      rq.left_in        = SAMPLE_BITS'(lv);
      rq.right_in       = SAMPLE_BITS'(rv);
      rq.new_volume     = VOL_W'(vol);
      rq.meter_was_read = rd;
      return rq;
   endfunction

   function automatic int pick_sample();
      case ($urandom_range(0, 9))
         0: return int'($urandom());
         1: begin
            case ($urandom_range(0, 3))
               0:       return 8388607;
               1:       return -8388608;
               2:       return 0;
               default: return -1;
            endcase
         end
         2, 3, 4: return int'($urandom_range(0, 66000)) - 33000;
         5, 6:    return int'($urandom_range(0, 600000)) - 300000;
         default: return int'($urandom_range(0, 8000)) - 4000;
      endcase
   endfunction

   function automatic int pick_volume();
      return ($urandom_range(0, 3) == 0) ? 255 : int'($urandom_range(0, 255));
   endfunction

   task automatic log_fault(input string what);
      faults++;
      if (faults <= 10) $display("response %0d: %s", reports_seen, what);
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         log_fault($sformatf("%s expected %h, got %h", name, want, got));
   endtask

   // mostly well-formed meter blocks with random content, some loose noise
   task automatic queue_random_phase(input int count);
      int added;
      int len;
      added = 0;
      while (added < count) begin
         if ($urandom_range(0, 9) < 8) begin
            len = $urandom_range(1, 12);
            req_backlog.push_back(make_req(KIND_START, $urandom(), $urandom(),
                                           $urandom_range(0, 255), 1'($urandom_range(0, 1))));
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(0, 99) < 12)
                  req_backlog.push_back(make_req(KIND_VOLUME, $urandom(), $urandom(),
                                                 pick_volume(), 1'($urandom_range(0, 1))));
               else
                  req_backlog.push_back(make_req(KIND_SAMPLE, pick_sample(), pick_sample(),
                                                 $urandom_range(0, 255),
                                                 1'($urandom_range(0, 1))));
            end
            req_backlog.push_back(make_req(KIND_END, $urandom(), $urandom(),
                                           $urandom_range(0, 255), 1'($urandom_range(0, 1))));
            added += len + 2;
         end else begin
            req_backlog.push_back(make_req(2'($urandom_range(0, 3)), pick_sample(),
                                           pick_sample(), pick_volume(),
                                           1'($urandom_range(0, 1))));
            added++;
         end
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || reports_due.size() != 0)
         @(negedge clock);
   endtask

   // write the mode register with the unit idle, then hand over at a rising edge
   task automatic start_phase(input bit cut_en, input bit calm);
      wait_drained();
      repeat (4) @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= cut_en;
      clip_cut_en     = cut_en;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
      steady = calm;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_backlog.size() > 0 && (steady || $urandom_range(0, 99) >= 32)) begin
            req_data  <= req_backlog[0];
            req_backlog.delete(0);
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_taken = 1'b0;
      rsp_stall <= !steady && ($urandom_range(0, 99) < 32);
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            reports_due.push_back(predict_report(req_data));
            req_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (reports_due.size() == 0) begin
               log_fault("response with no request outstanding");
            end else begin
               want = reports_due[0];
               reports_due.delete(0);
               check_field("left_out", rsp_data.left_out, want.left_out);
               check_field("right_out", rsp_data.right_out, want.right_out);
               check_field("peak_left_out", rsp_data.peak_left_out, want.peak_left_out);
               check_field("peak_right_out", rsp_data.peak_right_out, want.peak_right_out);
               check_field("overall_peak_out", rsp_data.overall_peak_out,
                           want.overall_peak_out);
               check_field("clipped", rsp_data.clipped, want.clipped);
               check_field("gain_now", rsp_data.gain_now, want.gain_now);
            end
            reports_seen++;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // plain gain path: meter floor, full-scale extremes, rounding ties, volume limits
      start_phase(1'b0, 1'b0);
      req_backlog.push_back(make_req(KIND_START, 0, 0, 0, 1'b1));
      req_backlog.push_back(make_req(KIND_END, 0, 0, 0, 1'b0));
      req_backlog.push_back(make_req(KIND_SAMPLE, 8388607, -8388608, 0, 1'b0));
      req_backlog.push_back(make_req(KIND_END, 0, 0, 0, 1'b0));
      req_backlog.push_back(make_req(KIND_START, 0, 0, 0, 1'b1));
      req_backlog.push_back(make_req(KIND_START, 0, 0, 0, 1'b0));
      req_backlog.push_back(make_req(KIND_VOLUME, 0, 0, 128, 1'b0));
      req_backlog.push_back(make_req(KIND_SAMPLE, 1, -1, 0, 1'b0));
      req_backlog.push_back(make_req(KIND_SAMPLE, 3, -3, 0, 1'b0));
      req_backlog.push_back(make_req(KIND_VOLUME, 0, 0, 0, 1'b0));
      req_backlog.push_back(make_req(KIND_SAMPLE, 1000, -1000, 0, 1'b0));
      req_backlog.push_back(make_req(KIND_VOLUME, 0, 0, 255, 1'b0));
      req_backlog.push_back(make_req(KIND_SAMPLE, 8388607, -8388608, 0, 1'b0));
      req_backlog.push_back(make_req(KIND_SAMPLE, 0, 0, 0, 1'b0));

      // clip reduction: exact threshold, gain drop within a pair, zero and minimum gain
      start_phase(1'b1, 1'b0);
      req_backlog.push_back(make_req(KIND_VOLUME, 0, 0, 128, 1'b0));
      req_backlog.push_back(make_req(KIND_SAMPLE, 65534, -65534, 0, 1'b0));
      req_backlog.push_back(make_req(KIND_SAMPLE, 65535, -65535, 0, 1'b0));
      req_backlog.push_back(make_req(KIND_VOLUME, 0, 0, 255, 1'b0));
      req_backlog.push_back(make_req(KIND_SAMPLE, 40000, 40000, 0, 1'b0));
      req_backlog.push_back(make_req(KIND_SAMPLE, -8388608, 8388607, 0, 1'b0));
      req_backlog.push_back(make_req(KIND_END, 0, 0, 0, 1'b0));
      req_backlog.push_back(make_req(KIND_VOLUME, 0, 0, 0, 1'b0));
      req_backlog.push_back(make_req(KIND_SAMPLE, -8388608, 8388607, 0, 1'b0));
      req_backlog.push_back(make_req(KIND_VOLUME, 0, 0, 1, 1'b0));
      req_backlog.push_back(make_req(KIND_SAMPLE, -8388608, -8388608, 0, 1'b0));
      req_backlog.push_back(make_req(KIND_END, 0, 0, 0, 1'b0));

      for (int ph = 0; ph < 8; ph++) begin
         start_phase((ph % 3) != 1, ph == 3);
         queue_random_phase(175);
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (faults == 0 && reports_due.size() == 0)
         $display("tb_master_gain_clip_peak_meter_unit OK");
      else
         $display("tb_master_gain_clip_peak_meter_unit NOT OK");
      $finish;
   end

   initial begin
      #8000000;
      $display("tb_master_gain_clip_peak_meter_unit NOT OK");
      $finish;
   end

endmodule
